// ----- hw/rtl/gmtd_pkg.sv -----
// Shared types and constants for the grid mass transport and deposition block.
// No dependencies.
package gmtd_pkg;
    localparam int GRID_CELLS_DEF = 4096;
    localparam int ROW_W_BITS     = 13;
    localparam int IDX_BITS       = 12;
    localparam int MASS_BITS      = 32;
    localparam int FRAC_BITS      = 17;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_PROCESS = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    typedef struct packed {
        logic [FRAC_BITS-1:0] top;
        logic [FRAC_BITS-1:0] left;
        logic [FRAC_BITS-1:0] right;
        logic [FRAC_BITS-1:0] bottom;
    } t_fracs;
endpackage

// ----- hw/rtl/gmtd_colsplit.sv -----
// Iterative column finder: index modulo row width by repeated subtraction of
// a shifted divisor, one bit per cycle. Depends on gmtd_pkg.
module gmtd_colsplit
    import gmtd_pkg::*;
#(
    parameter int IW = IDX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [IW-1:0]         i_index,
    input  logic [ROW_W_BITS-1:0] i_width,
    output logic                  o_done,
    output logic [IW-1:0]         o_col
);
    localparam int CW = $clog2(IW + 1);
    logic [IW:0]          r_rem, n_rem;
    logic [IW+ROW_W_BITS:0] r_div, n_div;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_busy, n_busy, r_done, n_done;

    always_comb begin
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = {1'b0, i_index};
            n_div  = {{(IW+1){1'b0}}, i_width} << IW;
            n_cnt  = CW'(IW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if ({{ROW_W_BITS{1'b0}}, r_rem} >= r_div)
                n_rem = r_rem - r_div[IW:0];
            n_div = r_div >> 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_col  = r_rem[IW-1:0];
endmodule

// ----- hw/rtl/grid_mass_transport_deposit_top.sv -----
// Top level of the grid mass transport and deposition block.
// Depends on gmtd_pkg and gmtd_colsplit.
// A load transfer writes its cell at the accepting edge, and the block stays ready.
// A read passes through the memory read, wait and result states before the block
// is ready again. A process transfer passes the read and wait states, then a
// column search on the subtractor in gmtd_colsplit and the deposition state. Each
// neighbor then takes a multiply state on the shared multiplier. A neighbor
// inside the grid adds a read, a wait and a write-back state on the single mass
// memory port. A neighbor outside the grid adds only the write state, which
// leaves the mass memory unchanged. After the last neighbor comes the output
// state. One output register holds a finished result, and new transfers are
// taken while it waits. A later result stays in its output state until that
// register drains.
module grid_mass_transport_deposit_top
    import gmtd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [ROW_W_BITS-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_action,
    input  logic [IDX_BITS-1:0]   i_cell_index,
    input  logic [MASS_BITS-1:0]  i_mass_in,
    input  logic [MASS_BITS-1:0]  i_deposit_limit_in,
    input  logic [MASS_BITS-1:0]  i_deposit_init_in,
    input  logic [FRAC_BITS-1:0]  i_frac_top,
    input  logic [FRAC_BITS-1:0]  i_frac_left,
    input  logic [FRAC_BITS-1:0]  i_frac_right,
    input  logic [FRAC_BITS-1:0]  i_frac_bottom,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [IDX_BITS-1:0]   o_out_index,
    output logic [MASS_BITS-1:0]  o_deposit_out,
    output logic                  o_edge_flag,
    output logic                  o_sat_flag
);
    localparam int GRID_CELLS = GRID_CELLS_DEF;
    localparam int AW = $clog2(GRID_CELLS);
    localparam int SW = AW + 2;

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_COL = 4'd3,
        S_DEP = 4'd4, S_NRD = 4'd5, S_NWAIT = 4'd6, S_NWR = 4'd7, S_OUT = 4'd8,
        S_MUL = 4'd9;

    logic [MASS_BITS-1:0] mass_mem [GRID_CELLS];
    logic [MASS_BITS-1:0] lim_mem  [GRID_CELLS];
    logic [MASS_BITS-1:0] dep_mem  [GRID_CELLS];
    t_fracs               frac_mem [GRID_CELLS];

    logic [3:0]            r_state;
    logic [ROW_W_BITS-1:0] r_width;
    logic [1:0]            r_act, r_k;
    logic [IDX_BITS-1:0]   r_idx;
    logic [MASS_BITS-1:0]  r_m, r_lim, r_dep, r_rd, r_nbm, r_rem;
    t_fracs                r_fr;
    logic [MASS_BITS+FRAC_BITS-1:0] r_prod;
    logic [AW-1:0]         r_nb;
    logic                  r_in, r_edge, r_sat, r_ov;
    logic [IDX_BITS-1:0]   col;
    logic                  col_done, col_start;
    logic [SW-1:0]         w_eff;

    assign w_eff = (r_width == '0) ? SW'(1) : SW'(r_width);
    assign o_ready = (r_state == S_IDLE);

    gmtd_colsplit #(.IW(IDX_BITS)) u_col (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(col_start),
        .i_index(r_idx), .i_width(w_eff[ROW_W_BITS-1:0] | ROW_W_BITS'(w_eff[SW-1:ROW_W_BITS] != 0)),
        .o_done(col_done), .o_col(col)
    );

    logic acc;
    logic out_load;
    assign acc = i_valid && o_ready;
    assign col_start = (r_state == S_RDW) && (r_act == ACT_PROCESS);
    // The result register takes a new result only once the previous one has left.
    assign out_load = (r_state == S_OUT) && (!r_ov || i_ready);

    // Neighbor selection for the current direction.
    logic [SW-1:0] ix, nb_sum;
    logic          nb_in;
    logic [FRAC_BITS-1:0] fsel;
    always_comb begin
        ix = SW'(r_idx);
        nb_in = 1'b0;
        nb_sum = '0;
        fsel = r_fr.top;
        unique case (r_k)
            2'd0: begin
                nb_in = ix >= w_eff; nb_sum = ix - w_eff; fsel = r_fr.top;
            end
            2'd1: begin
                nb_in = col != '0; nb_sum = ix - 1'b1; fsel = r_fr.left;
            end
            2'd2: begin
                nb_in = (SW'(col) + 1'b1 < w_eff) && (ix + 1'b1 < SW'(GRID_CELLS));
                nb_sum = ix + 1'b1; fsel = r_fr.right;
            end
            default: begin
                nb_in = ix + w_eff < SW'(GRID_CELLS); nb_sum = ix + w_eff;
                fsel = r_fr.bottom;
            end
        endcase
    end

    logic [MASS_BITS+FRAC_BITS-17:0] flow;
    logic [MASS_BITS:0]              msum;
    assign flow = r_prod[MASS_BITS+FRAC_BITS-1:16];
    assign msum = {1'b0, r_nbm} + {1'b0, flow[MASS_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (acc && i_action == ACT_LOAD && 32'(i_cell_index) < GRID_CELLS) begin
            lim_mem[i_cell_index[AW-1:0]]  <= i_deposit_limit_in;
            frac_mem[i_cell_index[AW-1:0]] <= {i_frac_top, i_frac_left, i_frac_right,
                                               i_frac_bottom};
        end
        if (r_state == S_DEP) dep_mem[r_idx[AW-1:0]] <= r_dep;
        else if (acc && i_action == ACT_LOAD && 32'(i_cell_index) < GRID_CELLS)
            dep_mem[i_cell_index[AW-1:0]] <= i_deposit_init_in;
        if (r_state == S_NWR && r_in) begin
            mass_mem[r_nb] <= (msum[MASS_BITS] || flow[MASS_BITS+FRAC_BITS-17:MASS_BITS] != 0)
                              ? '1 : msum[MASS_BITS-1:0];
        end else if (acc && i_action == ACT_LOAD && 32'(i_cell_index) < GRID_CELLS)
            mass_mem[i_cell_index[AW-1:0]] <= i_mass_in;
        if (r_state == S_RD) begin
            r_m   <= mass_mem[r_idx[AW-1:0]];
            r_lim <= lim_mem[r_idx[AW-1:0]];
            r_rd  <= dep_mem[r_idx[AW-1:0]];
            r_fr  <= frac_mem[r_idx[AW-1:0]];
        end
        if (r_state == S_NRD) r_nbm <= mass_mem[r_nb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= ROW_W_BITS'(64);
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) r_width <= i_cfg_data;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (acc && 32'(i_cell_index) < GRID_CELLS
                            && (i_action == ACT_PROCESS || i_action == ACT_READ)) begin
                    r_state <= S_RD;
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: r_state <= (r_act == ACT_PROCESS) ? S_COL : S_OUT;
                S_COL: if (col_done) r_state <= S_DEP;
                S_DEP: r_state <= S_MUL;
                S_MUL: r_state <= nb_in ? S_NRD : S_NWR;
                S_NRD: r_state <= S_NWAIT;
                S_NWAIT: r_state <= S_NWR;
                S_NWR: r_state <= (r_k == 2'd3) ? S_OUT : S_MUL;
                S_OUT: if (out_load) begin
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (acc) begin
            r_act <= i_action;
            r_idx <= i_cell_index;
        end
        if (r_state == S_RDW) begin
            r_dep  <= (r_m < r_lim) ? r_m : r_lim;
            r_edge <= 1'b0;
            r_sat  <= 1'b0;
            r_k    <= 2'd0;
        end
        if (r_state == S_DEP) r_rem <= r_m - r_dep;
        if (r_state == S_MUL) begin
            r_prod <= r_rem * fsel;
            r_in   <= nb_in;
            r_nb   <= nb_sum[AW-1:0];
        end
        // After S_MUL, r_in is valid in the next state; outside cells skip the write.
        if (r_state == S_NWR) begin
            if (!r_in) begin
                if (flow != 0) r_edge <= 1'b1;
            end else if (msum[MASS_BITS] || flow[MASS_BITS+FRAC_BITS-17:MASS_BITS] != 0) begin
                r_sat <= 1'b1;
            end
            r_k <= r_k + 1'b1;
        end
        if (out_load) begin
            o_out_index   <= r_idx;
            o_deposit_out <= (r_act == ACT_PROCESS) ? r_dep : r_rd;
            o_edge_flag   <= (r_act == ACT_PROCESS) && r_edge;
            o_sat_flag    <= (r_act == ACT_PROCESS) && r_sat;
        end
    end

    assign o_valid = r_ov;

    // The block takes no new transfer while it works on one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_valid) else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_deposit_out)
                                   && $stable(o_out_index)))
        else $error("result changed");
endmodule
